### hw/rtl/sprite_animation_sequencer_defines.svh
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_defines
// Assertion macros used by the sprite animation sequencer controller (sas_ctrl).
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sas assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sas assertion failed");

`endif

### hw/rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Types, codes and sizes shared by the sprite animation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  localparam int NUM_INST   = 8;
  localparam int SLOT_W     = 3;
  localparam int NUM_CLIPS  = 16;
  localparam int CLIP_W     = 4;
  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = 4;
  localparam int FCNT_W     = 5;
  localparam int TIME_W     = 16;
  localparam int SPR_W      = 8;
  localparam int POS_W      = 16;
  localparam int PRIO_W     = 8;
  localparam int LOOP_W     = 8;
  localparam int FADDR_W    = CLIP_W + FRAME_W;
  localparam int FDEPTH     = NUM_CLIPS * MAX_FRAMES;
  localparam int FDATA_W    = TIME_W + SPR_W + 2 * POS_W;
  localparam int MODCNT_W   = 4;

  // Request codes
  localparam logic [3:0] REQ_DEFINE   = 4'd0;
  localparam logic [3:0] REQ_LOAD     = 4'd1;
  localparam logic [3:0] REQ_PLAY     = 4'd2;
  localparam logic [3:0] REQ_STOP     = 4'd3;
  localparam logic [3:0] REQ_PAUSE    = 4'd4;
  localparam logic [3:0] REQ_RESUME   = 4'd5;
  localparam logic [3:0] REQ_STOP_ALL = 4'd6;
  localparam logic [3:0] REQ_TICK     = 4'd7;
  localparam logic [3:0] REQ_RENDER   = 4'd8;
  localparam logic [3:0] REQ_QUERY    = 4'd9;
  localparam logic [3:0] REQ_UNLOAD   = 4'd10;

  // Clip play modes
  localparam logic [2:0] MODE_LOOP     = 3'd0;
  localparam logic [2:0] MODE_PINGPONG = 3'd1;
  localparam logic [2:0] MODE_ONCE     = 3'd2;
  localparam logic [2:0] MODE_HOLD     = 3'd3;
  localparam logic [2:0] MODE_RANDOM   = 3'd4;

  // Instance states
  localparam logic [1:0] IST_STOPPED  = 2'd0;
  localparam logic [1:0] IST_PLAYING  = 2'd1;
  localparam logic [1:0] IST_PAUSED   = 2'd2;
  localparam logic [1:0] IST_FINISHED = 2'd3;
  localparam logic [2:0] ANIM_NOT_FOUND = 3'd4;

  localparam logic [15:0]       LFSR_SEED = 16'hACE1;
  localparam logic [15:0]       LFSR_MASK = 16'hB400;
  localparam logic [PRIO_W-1:0] PRIO_TOP  = 8'd255;

  typedef struct packed {
    logic [3:0]              req_type;
    logic [CLIP_W-1:0]       clip_id;
    logic [2:0]              mode;
    logic [FCNT_W-1:0]       frame_count;
    logic [FRAME_W-1:0]      frame_index;
    logic [TIME_W-1:0]       time_value;
    logic [SPR_W-1:0]        sprite_frame;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PRIO_W-1:0]       priority_req;
  } in_item_t;

  typedef struct packed {
    logic                    req_ok;
    logic [SLOT_W-1:0]       slot;
    logic [CLIP_W-1:0]       result_clip;
    logic                    draw_valid;
    logic [SPR_W-1:0]        draw_sprite;
    logic signed [POS_W-1:0] draw_x;
    logic signed [POS_W-1:0] draw_y;
    logic [2:0]              anim_state;
    logic [FRAME_W-1:0]      current_frame;
    logic [LOOP_W-1:0]       loop_count;
    logic                    last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic                latch;
    logic                rd;
    logic                ex;
    logic                mod_step;
    logic                mod_last;
    logic                fin;
    logic [SLOT_W-1:0]   slot;
    logic [MODCNT_W-1:0] mod_bit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_render;
    logic is_tick;
    logic need_mod;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/sas_if.sv
// ----------------------------------------------------------------------------
// sas_in_if / sas_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sas_in_if import sas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [3:0]              req_type;
  logic [CLIP_W-1:0]       clip_id;
  logic [2:0]              mode;
  logic [FCNT_W-1:0]       frame_count;
  logic [FRAME_W-1:0]      frame_index;
  logic [TIME_W-1:0]       time_value;
  logic [SPR_W-1:0]        sprite_frame;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [PRIO_W-1:0]       priority_req;

  modport source (output valid, req_type, clip_id, mode, frame_count, frame_index,
                  time_value, sprite_frame, pos_x, pos_y, priority_req, input ready);
  modport sink (input valid, req_type, clip_id, mode, frame_count, frame_index,
                time_value, sprite_frame, pos_x, pos_y, priority_req, output ready);
endinterface

interface sas_out_if import sas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_ok;
  logic [SLOT_W-1:0]       slot;
  logic [CLIP_W-1:0]       result_clip;
  logic                    draw_valid;
  logic [SPR_W-1:0]        draw_sprite;
  logic signed [POS_W-1:0] draw_x;
  logic signed [POS_W-1:0] draw_y;
  logic [2:0]              anim_state;
  logic [FRAME_W-1:0]      current_frame;
  logic [LOOP_W-1:0]       loop_count;
  logic                    last;

  modport source (output valid, req_ok, slot, result_clip, draw_valid, draw_sprite,
                  draw_x, draw_y, anim_state, current_frame, loop_count, last,
                  input ready);
  modport sink (input valid, req_ok, slot, result_clip, draw_valid, draw_sprite,
                draw_x, draw_y, anim_state, current_frame, loop_count, last,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sas_ctrl.sv
// ----------------------------------------------------------------------------
// sas_ctrl
// Request sequencer: walks the instance slots and runs the modulo unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sprite_animation_sequencer_defines.svh"

module sas_ctrl import sas_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EX   = 3'd2;
  localparam logic [2:0] ST_MOD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(NUM_INST - 1);
  localparam logic [MODCNT_W-1:0] MOD_LAST  = '1;

  logic [2:0]          state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [MODCNT_W-1:0] mcnt_r, mcnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    mcnt_nxt  = mcnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.slot  = slot_r;
    cmd.mod_bit = ~mcnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          slot_nxt  = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        if (!status.is_render || status.out_free) begin
          cmd.ex = 1'b1;
          if (status.need_mod) begin
            mcnt_nxt  = '0;
            state_nxt = ST_MOD;
          end else if (slot_r == SLOT_LAST) begin
            state_nxt = ST_FIN;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        mcnt_nxt     = mcnt_r + 1'b1;
        if (mcnt_r == MOD_LAST) begin
          cmd.mod_last = 1'b1;
          if (slot_r == SLOT_LAST) begin
            state_nxt = ST_FIN;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (status.is_render) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      mcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  `SAS_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, state_r == ST_IDLE && in_valid, state_r == ST_RD && slot_r == '0)
  `SAS_ASSERT_NOW(a_mod_only_on_tick, clk, rst_n, state_r == ST_MOD, status.is_tick)
  `SAS_ASSERT_NEXT(a_last_slot_to_fin, clk, rst_n, state_r == ST_EX && slot_r == SLOT_LAST && cmd.ex && !status.need_mod, state_r == ST_FIN)

endmodule

`default_nettype wire

### hw/rtl/sas_datapath.sv
// ----------------------------------------------------------------------------
// sas_datapath
// Clip and instance tables, frame RAM, slot step logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_datapath import sas_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // Latched request
  in_item_t rq_r, rq_nxt;

  // Clip table
  logic              clip_valid_r  [NUM_CLIPS];
  logic              clip_valid_nxt[NUM_CLIPS];
  logic [2:0]        clip_mode_r   [NUM_CLIPS];
  logic [2:0]        clip_mode_nxt [NUM_CLIPS];
  logic [FCNT_W-1:0] clip_frames_r [NUM_CLIPS];
  logic [FCNT_W-1:0] clip_frames_nxt[NUM_CLIPS];

  // Instance table
  logic               act_r   [NUM_INST];
  logic               act_nxt [NUM_INST];
  logic [CLIP_W-1:0]  iclip_r [NUM_INST];
  logic [CLIP_W-1:0]  iclip_nxt[NUM_INST];
  logic [1:0]         ist_r   [NUM_INST];
  logic [1:0]         ist_nxt [NUM_INST];
  logic [FRAME_W-1:0] ifrm_r  [NUM_INST];
  logic [FRAME_W-1:0] ifrm_nxt[NUM_INST];
  logic [TIME_W-1:0]  itmr_r  [NUM_INST];
  logic [TIME_W-1:0]  itmr_nxt[NUM_INST];
  logic               iback_r [NUM_INST];
  logic               iback_nxt[NUM_INST];
  logic [LOOP_W-1:0]  iloop_r [NUM_INST];
  logic [LOOP_W-1:0]  iloop_nxt[NUM_INST];
  logic [PRIO_W-1:0]  iprio_r [NUM_INST];
  logic [PRIO_W-1:0]  iprio_nxt[NUM_INST];

  logic [15:0]        lfsr_r, lfsr_nxt;
  logic [FRAME_W-1:0] rem_r, rem_nxt;

  // Slot search accumulators
  logic              fnd_v_r, fnd_v_nxt, free_v_r, free_v_nxt, low_v_r, low_v_nxt;
  logic [SLOT_W-1:0] fnd_i_r, fnd_i_nxt, free_i_r, free_i_nxt, low_i_r, low_i_nxt;
  logic [PRIO_W-1:0] low_r, low_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Frame RAM
  logic               ram_we;
  logic [FADDR_W-1:0] ram_waddr;
  logic [FDATA_W-1:0] ram_wdata;
  logic [FADDR_W-1:0] ram_raddr;
  logic [FDATA_W-1:0] ram_rdata;

  // Current slot view
  logic [SLOT_W-1:0]  sl;
  logic [CLIP_W-1:0]  ic;
  logic [FCNT_W-1:0]  n;
  logic [2:0]         cmode;
  logic [TIME_W-1:0]  fdur;
  logic [SPR_W-1:0]   fspr;
  logic [POS_W-1:0]   foffx, foffy;
  logic [TIME_W:0]    tsum;
  logic [TIME_W-1:0]  tsat;
  logic               playing, due;
  logic [FCNT_W-1:0]  fcl, g;
  logic [FCNT_W:0]    msh;
  logic [FCNT_W:0]    mres;
  logic               def_ok, drop_on;
  logic               out_free;

  assign sl      = cmd.slot;
  assign ic      = iclip_r[sl];
  assign n       = clip_frames_r[ic];
  assign cmode   = clip_mode_r[ic];
  assign fdur    = ram_rdata[FDATA_W-1 -: TIME_W];
  assign fspr    = ram_rdata[2*POS_W +: SPR_W];
  assign foffx   = ram_rdata[POS_W +: POS_W];
  assign foffy   = ram_rdata[0 +: POS_W];
  assign tsum    = {1'b0, itmr_r[sl]} + {1'b0, rq_r.time_value};
  assign tsat    = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
  assign playing = act_r[sl] && (ist_r[sl] == IST_PLAYING);
  assign due     = (n != '0) && (tsat >= fdur);
  assign fcl     = ({1'b0, ifrm_r[sl]} >= n) ? n - 1'b1 : {1'b0, ifrm_r[sl]};
  assign def_ok  = (rq_r.frame_count <= FCNT_W'(MAX_FRAMES)) && (rq_r.mode <= MODE_RANDOM);
  assign drop_on = ((rq_r.req_type == REQ_DEFINE) && def_ok) ||
                   ((rq_r.req_type == REQ_UNLOAD) && clip_valid_r[rq_r.clip_id]);
  assign out_free = !out_valid_r || out_ready;

  // Modulo unit: one bit of the stepped LFSR per cycle
  assign msh  = {1'b0, rem_r, lfsr_r[cmd.mod_bit]};
  assign mres = (msh >= {1'b0, n}) ? msh - {1'b0, n} : msh;

  assign ram_raddr = {ic, ifrm_r[sl]};
  assign ram_waddr = {rq_r.clip_id, rq_r.frame_index};
  assign ram_wdata = {rq_r.time_value, rq_r.sprite_frame, rq_r.pos_x, rq_r.pos_y};
  assign ram_we    = cmd.fin && (rq_r.req_type == REQ_LOAD) && clip_valid_r[rq_r.clip_id] &&
                     ({1'b0, rq_r.frame_index} < clip_frames_r[rq_r.clip_id]);

  assign status.is_render = (rq_r.req_type == REQ_RENDER);
  assign status.is_tick   = (rq_r.req_type == REQ_TICK);
  assign status.need_mod  = status.is_tick && playing && due && (cmode == MODE_RANDOM);
  assign status.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  sas_ram #(.WIDTH(FDATA_W), .DEPTH(FDEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic for tables, search and result
  always_comb begin
    logic [SLOT_W-1:0] s;
    logic              s_v;
    logic [15:0]       lf;
    rq_nxt          = rq_r;
    clip_valid_nxt  = clip_valid_r;
    clip_mode_nxt   = clip_mode_r;
    clip_frames_nxt = clip_frames_r;
    act_nxt   = act_r;
    iclip_nxt = iclip_r;
    ist_nxt   = ist_r;
    ifrm_nxt  = ifrm_r;
    itmr_nxt  = itmr_r;
    iback_nxt = iback_r;
    iloop_nxt = iloop_r;
    iprio_nxt = iprio_r;
    lfsr_nxt  = lfsr_r;
    rem_nxt   = rem_r;
    fnd_v_nxt = fnd_v_r;
    fnd_i_nxt = fnd_i_r;
    free_v_nxt = free_v_r;
    free_i_nxt = free_i_r;
    low_v_nxt = low_v_r;
    low_i_nxt = low_i_r;
    low_nxt   = low_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt   = out_r;
    g         = '0;
    s         = '0;
    s_v       = 1'b0;
    lf        = '0;

    // New request
    if (cmd.latch) begin
      rq_nxt     = in_item;
      fnd_v_nxt  = 1'b0;
      free_v_nxt = 1'b0;
      low_v_nxt  = 1'b0;
      low_nxt    = PRIO_TOP;
    end

    // One slot of the walk
    if (cmd.ex) begin
      case (rq_r.req_type)
        REQ_TICK: begin
          if (playing) begin
            itmr_nxt[sl] = tsat;
            if (due) begin
              itmr_nxt[sl] = tsat - fdur;
              ifrm_nxt[sl] = fcl[FRAME_W-1:0];
              case (cmode)
                MODE_LOOP: begin
                  if (fcl + 1'b1 == n) begin
                    ifrm_nxt[sl]  = '0;
                    iloop_nxt[sl] = iloop_r[sl] + 1'b1;
                  end else begin
                    ifrm_nxt[sl] = FRAME_W'(fcl + 1'b1);
                  end
                end
                MODE_PINGPONG: begin
                  if (n == FCNT_W'(1)) begin
                    ifrm_nxt[sl] = '0;
                  end else begin
                    if (iback_r[sl]) begin
                      g = (fcl == '0) ? '0 : fcl - 1'b1;
                    end else begin
                      g = fcl + 1'b1;
                    end
                    if (g >= n - 1'b1) begin
                      ifrm_nxt[sl]  = FRAME_W'(n - 1'b1);
                      iback_nxt[sl] = 1'b1;
                    end else begin
                      ifrm_nxt[sl] = g[FRAME_W-1:0];
                      if (g == '0) begin
                        iback_nxt[sl] = 1'b0;
                        iloop_nxt[sl] = iloop_r[sl] + 1'b1;
                      end
                    end
                  end
                end
                MODE_ONCE, MODE_HOLD: begin
                  if (fcl < n - 1'b1) begin
                    ifrm_nxt[sl] = FRAME_W'(fcl + 1'b1);
                  end else begin
                    ist_nxt[sl] = IST_FINISHED;
                  end
                end
                MODE_RANDOM: begin
                  lf = lfsr_r >> 1;
                  if (lfsr_r[0]) begin
                    lf = lf ^ LFSR_MASK;
                  end
                  lfsr_nxt = lf;
                  rem_nxt  = '0;
                end
                default: begin
                end
              endcase
            end
          end
        end
        REQ_RENDER: begin
          out_valid_nxt     = 1'b1;
          out_nxt           = '0;
          out_nxt.req_ok    = 1'b1;
          out_nxt.slot      = sl;
          out_nxt.last      = (sl == SLOT_W'(NUM_INST - 1));
          if (act_r[sl] && (ist_r[sl] != IST_STOPPED) && clip_valid_r[ic] && (n != '0)) begin
            out_nxt.result_clip = ic;
            out_nxt.draw_valid  = 1'b1;
            out_nxt.draw_sprite = fspr;
            out_nxt.draw_x      = rq_r.pos_x + foffx;
            out_nxt.draw_y      = rq_r.pos_y + foffy;
          end
        end
        default: begin
          if (!fnd_v_r && act_r[sl] && (iclip_r[sl] == rq_r.clip_id)) begin
            fnd_v_nxt = 1'b1;
            fnd_i_nxt = sl;
          end
          if (!free_v_r && !act_r[sl]) begin
            free_v_nxt = 1'b1;
            free_i_nxt = sl;
          end
          if (act_r[sl] && (iprio_r[sl] < low_r)) begin
            low_v_nxt = 1'b1;
            low_i_nxt = sl;
            low_nxt   = iprio_r[sl];
          end
          if (drop_on && act_r[sl] && (iclip_r[sl] == rq_r.clip_id)) begin
            act_nxt[sl] = 1'b0;
            ist_nxt[sl] = IST_STOPPED;
          end
        end
      endcase
    end

    // Random frame from the modulo unit
    if (cmd.mod_step) begin
      rem_nxt = mres[FRAME_W-1:0];
      if (cmd.mod_last) begin
        ifrm_nxt[sl] = mres[FRAME_W-1:0];
      end
    end

    // Request completion and its single result
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      out_nxt.last  = 1'b1;
      case (rq_r.req_type)
        REQ_DEFINE: begin
          if (def_ok) begin
            clip_valid_nxt[rq_r.clip_id]  = 1'b1;
            clip_mode_nxt[rq_r.clip_id]   = rq_r.mode;
            clip_frames_nxt[rq_r.clip_id] = rq_r.frame_count;
            out_nxt.req_ok = 1'b1;
          end
        end
        REQ_LOAD: begin
          out_nxt.req_ok = ram_we;
        end
        REQ_PLAY: begin
          if (clip_valid_r[rq_r.clip_id]) begin
            if (fnd_v_r) begin
              s = fnd_i_r;
              s_v = 1'b1;
            end else if (free_v_r) begin
              s = free_i_r;
              s_v = 1'b1;
            end else if (low_v_r && (low_r <= rq_r.priority_req)) begin
              s = low_i_r;
              s_v = 1'b1;
            end
            if (s_v) begin
              if (!fnd_v_r) begin
                iclip_nxt[s] = rq_r.clip_id;
                iprio_nxt[s] = rq_r.priority_req;
                act_nxt[s]   = 1'b1;
              end
              ist_nxt[s]   = IST_PLAYING;
              ifrm_nxt[s]  = '0;
              itmr_nxt[s]  = '0;
              iback_nxt[s] = 1'b0;
              iloop_nxt[s] = '0;
              out_nxt.req_ok      = 1'b1;
              out_nxt.slot        = s;
              out_nxt.result_clip = rq_r.clip_id;
            end
          end
        end
        REQ_STOP, REQ_PAUSE, REQ_RESUME: begin
          if (fnd_v_r) begin
            if (rq_r.req_type == REQ_STOP) begin
              act_nxt[fnd_i_r] = 1'b0;
              ist_nxt[fnd_i_r] = IST_STOPPED;
            end else if (rq_r.req_type == REQ_PAUSE) begin
              ist_nxt[fnd_i_r] = IST_PAUSED;
            end else begin
              ist_nxt[fnd_i_r] = IST_PLAYING;
            end
            out_nxt.req_ok      = 1'b1;
            out_nxt.slot        = fnd_i_r;
            out_nxt.result_clip = iclip_r[fnd_i_r];
          end
        end
        REQ_STOP_ALL: begin
          for (int i = 0; i < NUM_INST; i++) begin
            act_nxt[i] = 1'b0;
            ist_nxt[i] = IST_STOPPED;
          end
          out_nxt.req_ok = 1'b1;
        end
        REQ_TICK: begin
          out_nxt.req_ok = 1'b1;
        end
        REQ_QUERY: begin
          if (fnd_v_r) begin
            out_nxt.req_ok        = 1'b1;
            out_nxt.slot          = fnd_i_r;
            out_nxt.result_clip   = iclip_r[fnd_i_r];
            out_nxt.anim_state    = {1'b0, ist_r[fnd_i_r]};
            out_nxt.current_frame = ifrm_r[fnd_i_r];
            out_nxt.loop_count    = iloop_r[fnd_i_r];
          end else begin
            out_nxt.anim_state = ANIM_NOT_FOUND;
          end
        end
        REQ_UNLOAD: begin
          if (clip_valid_r[rq_r.clip_id]) begin
            clip_valid_nxt[rq_r.clip_id] = 1'b0;
            out_nxt.req_ok = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLIPS; i++) begin
        clip_valid_r[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_INST; i++) begin
        act_r[i]   <= 1'b0;
        iclip_r[i] <= '0;
        ist_r[i]   <= IST_STOPPED;
        ifrm_r[i]  <= '0;
        itmr_r[i]  <= '0;
        iback_r[i] <= 1'b0;
        iloop_r[i] <= '0;
        iprio_r[i] <= '0;
      end
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      clip_valid_r <= clip_valid_nxt;
      act_r        <= act_nxt;
      iclip_r      <= iclip_nxt;
      ist_r        <= ist_nxt;
      ifrm_r       <= ifrm_nxt;
      itmr_r       <= itmr_nxt;
      iback_r      <= iback_nxt;
      iloop_r      <= iloop_nxt;
      iprio_r      <= iprio_nxt;
      lfsr_r       <= lfsr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rq_r          <= rq_nxt;
    clip_mode_r   <= clip_mode_nxt;
    clip_frames_r <= clip_frames_nxt;
    rem_r         <= rem_nxt;
    fnd_v_r       <= fnd_v_nxt;
    fnd_i_r       <= fnd_i_nxt;
    free_v_r      <= free_v_nxt;
    free_i_r      <= free_i_nxt;
    low_v_r       <= low_v_nxt;
    low_i_r       <= low_i_nxt;
    low_r         <= low_nxt;
    out_r         <= out_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// Clip and instance tables for sprite animation, with tick and render.
// ----------------------------------------------------------------------------
// Every request walks all eight instance slots, a frame RAM read and then
// an update for each, and then finishes; a tick also runs the bit-serial
// modulo unit, which resolves one LFSR bit per cycle, for each slot that
// steps a random-mode clip. Render returns eight results, one per slot in
// order, the last flagged; it holds its walk while the result register is
// full. All other requests return one result. The next request is accepted
// once the previous one has left its result in the output register. Frame
// entries that were never loaded read back as arbitrary data.
`default_nettype none

module sprite_animation_sequencer import sas_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sas_in_if.sink    in_if,
  sas_out_if.source out_if
);

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  // Request payload
  assign in_item.req_type     = in_if.req_type;
  assign in_item.clip_id      = in_if.clip_id;
  assign in_item.mode         = in_if.mode;
  assign in_item.frame_count  = in_if.frame_count;
  assign in_item.frame_index  = in_if.frame_index;
  assign in_item.time_value   = in_if.time_value;
  assign in_item.sprite_frame = in_if.sprite_frame;
  assign in_item.pos_x        = in_if.pos_x;
  assign in_item.pos_y        = in_if.pos_y;
  assign in_item.priority_req = in_if.priority_req;
  assign in_if.ready          = in_ready;

  // Result payload
  assign out_if.valid         = out_valid;
  assign out_if.req_ok        = out_item.req_ok;
  assign out_if.slot          = out_item.slot;
  assign out_if.result_clip   = out_item.result_clip;
  assign out_if.draw_valid    = out_item.draw_valid;
  assign out_if.draw_sprite   = out_item.draw_sprite;
  assign out_if.draw_x        = out_item.draw_x;
  assign out_if.draw_y        = out_item.draw_y;
  assign out_if.anim_state    = out_item.anim_state;
  assign out_if.current_frame = out_item.current_frame;
  assign out_if.loop_count    = out_item.loop_count;
  assign out_if.last          = out_item.last;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sas_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### dv/tb_sprite_animation_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_animation_sequencer
// Self-checking bench for the sprite animation sequencer. A directed table
// covers refusals, extremes and each request kind; random traffic follows,
// built so clips are defined and fully loaded before they play. A software
// model of the clip and instance tables predicts every result, and both
// channel sides idle at random, with one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_sprite_animation_sequencer;
  import sas_pkg::*;

  localparam int RAND_ITEMS = 352;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;
  localparam int IN_W       = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sas_in_if  in_if ();
  sas_out_if out_if ();

  sprite_animation_sequencer dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the clip and instance tables
  logic                clip_ok   [NUM_CLIPS];
  logic [2:0]          clip_md   [NUM_CLIPS];
  logic [FCNT_W-1:0]   clip_len  [NUM_CLIPS];
  logic [TIME_W-1:0]   fr_dur    [FDEPTH];
  logic [SPR_W-1:0]    fr_spr    [FDEPTH];
  logic [POS_W-1:0]    fr_dx     [FDEPTH];
  logic [POS_W-1:0]    fr_dy     [FDEPTH];
  bit                  fr_loaded [FDEPTH];
  logic                sl_act    [NUM_INST];
  logic [CLIP_W-1:0]   sl_clip   [NUM_INST];
  logic [1:0]          sl_st     [NUM_INST];
  logic [FRAME_W-1:0]  sl_frame  [NUM_INST];
  logic [TIME_W-1:0]   sl_timer  [NUM_INST];
  logic                sl_back   [NUM_INST];
  logic [LOOP_W-1:0]   sl_loops  [NUM_INST];
  logic [PRIO_W-1:0]   sl_prio   [NUM_INST];
  logic [15:0]         rng;

  out_item_t pending_results[$];
  int        errors = 0;
  int        idle_cycles = 0;

  function automatic int fidx(int c, int f);
    return c * MAX_FRAMES + f;
  endfunction

  function automatic out_item_t blank_result(logic ok);
    out_item_t r;
    r = '0;
    r.req_ok = ok;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void drop_slots_on(int c);
    for (int i = 0; i < NUM_INST; i++)
      if (sl_act[i] && sl_clip[i] == c) begin
        sl_act[i] = 1'b0;
        sl_st[i] = IST_STOPPED;
      end
  endfunction

  function automatic int slot_of(int c);
    for (int i = 0; i < NUM_INST; i++)
      if (sl_act[i] && sl_clip[i] == c) return i;
    return -1;
  endfunction

  // One frame step of a slot, per clip mode
  function automatic void step_frame(int i);
    int n, f, c;
    logic lsb;
    c = sl_clip[i];
    n = clip_len[c];
    f = sl_frame[i];
    if (n == 0) return;
    if (f >= n) f = n - 1;
    case (clip_md[c])
      MODE_LOOP: begin
        f = (f + 1) % n;
        if (f == 0) sl_loops[i]++;
      end
      MODE_PINGPONG: begin
        if (n == 1) f = 0;
        else begin
          if (sl_back[i]) f = (f == 0) ? 0 : f - 1;
          else f = f + 1;
          if (f >= n - 1) begin
            f = n - 1;
            sl_back[i] = 1'b1;
          end else if (f == 0) begin
            sl_back[i] = 1'b0;
            sl_loops[i]++;
          end
        end
      end
      MODE_ONCE, MODE_HOLD: begin
        if (f < n - 1) f++;
        else sl_st[i] = IST_FINISHED;
      end
      MODE_RANDOM: begin
        lsb = rng[0];
        rng = rng >> 1;
        if (lsb) rng ^= LFSR_MASK;
        f = rng % n;
      end
      default: ;
    endcase
    sl_frame[i] = f[FRAME_W-1:0];
  endfunction

  // Works out the results of one accepted request and queues them
  function automatic void predict_request(in_item_t it);
    int c, s, low_i, a;
    logic ok;
    int unsigned t, d, low;
    out_item_t r;
    c = it.clip_id;
    s = -1;
    ok = 1'b0;
    case (it.req_type)
      REQ_DEFINE:
        if (it.frame_count <= MAX_FRAMES && it.mode <= MODE_RANDOM) begin
          drop_slots_on(c);
          clip_ok[c] = 1'b1;
          clip_md[c] = it.mode;
          clip_len[c] = it.frame_count;
          ok = 1'b1;
        end
      REQ_LOAD:
        if (clip_ok[c] && it.frame_index < clip_len[c]) begin
          a = fidx(c, it.frame_index);
          fr_dur[a] = it.time_value;
          fr_spr[a] = it.sprite_frame;
          fr_dx[a] = it.pos_x;
          fr_dy[a] = it.pos_y;
          fr_loaded[a] = 1'b1;
          ok = 1'b1;
        end
      REQ_PLAY:
        if (clip_ok[c]) begin
          s = slot_of(c);
          if (s < 0) begin
            for (int i = 0; i < NUM_INST; i++)
              if (!sl_act[i] && s < 0) s = i;
            if (s < 0) begin
              low = PRIO_TOP;
              low_i = -1;
              for (int i = 0; i < NUM_INST; i++)
                if (sl_act[i] && sl_prio[i] < low) begin
                  low = sl_prio[i];
                  low_i = i;
                end
              if (low_i >= 0 && low <= it.priority_req) s = low_i;
            end
            if (s >= 0) begin
              sl_clip[s] = CLIP_W'(c);
              sl_prio[s] = it.priority_req;
              sl_act[s] = 1'b1;
            end
          end
          if (s >= 0) begin
            sl_st[s] = IST_PLAYING;
            sl_frame[s] = '0;
            sl_timer[s] = '0;
            sl_back[s] = 1'b0;
            sl_loops[s] = '0;
            ok = 1'b1;
          end
        end
      REQ_STOP, REQ_PAUSE, REQ_RESUME: begin
        s = slot_of(c);
        if (s >= 0) begin
          if (it.req_type == REQ_STOP) begin
            sl_act[s] = 1'b0;
            sl_st[s] = IST_STOPPED;
          end else begin
            sl_st[s] = (it.req_type == REQ_PAUSE) ? IST_PAUSED : IST_PLAYING;
          end
          ok = 1'b1;
        end
      end
      REQ_STOP_ALL: begin
        for (int i = 0; i < NUM_INST; i++) begin
          sl_act[i] = 1'b0;
          sl_st[i] = IST_STOPPED;
        end
        ok = 1'b1;
      end
      REQ_TICK: begin
        for (int i = 0; i < NUM_INST; i++) begin
          if (!sl_act[i] || sl_st[i] != IST_PLAYING) continue;
          t = sl_timer[i] + it.time_value;
          if (t > 16'hFFFF) t = 16'hFFFF;
          sl_timer[i] = t[15:0];
          if (clip_len[sl_clip[i]] == 0) continue;
          d = fr_dur[fidx(sl_clip[i], sl_frame[i])];
          if (t >= d) begin
            sl_timer[i] = TIME_W'(t - d);
            step_frame(i);
          end
        end
        ok = 1'b1;
      end
      REQ_RENDER: begin
        for (int i = 0; i < NUM_INST; i++) begin
          r = '0;
          r.req_ok = 1'b1;
          r.slot = SLOT_W'(i);
          r.last = (i == NUM_INST - 1);
          if (sl_act[i] && sl_st[i] != IST_STOPPED && clip_ok[sl_clip[i]]
              && clip_len[sl_clip[i]] != 0) begin
            a = fidx(sl_clip[i], sl_frame[i]);
            r.result_clip = sl_clip[i];
            r.draw_valid = 1'b1;
            r.draw_sprite = fr_spr[a];
            r.draw_x = it.pos_x + fr_dx[a];
            r.draw_y = it.pos_y + fr_dy[a];
          end
          pending_results.push_back(r);
        end
        return;
      end
      REQ_QUERY: begin
        s = slot_of(c);
        r = blank_result(s >= 0);
        if (s < 0) r.anim_state = ANIM_NOT_FOUND;
        else begin
          r.slot = SLOT_W'(s);
          r.result_clip = sl_clip[s];
          r.anim_state = {1'b0, sl_st[s]};
          r.current_frame = sl_frame[s];
          r.loop_count = sl_loops[s];
        end
        pending_results.push_back(r);
        return;
      end
      REQ_UNLOAD:
        if (clip_ok[c]) begin
          drop_slots_on(c);
          clip_ok[c] = 1'b0;
          ok = 1'b1;
        end
      default: ;
    endcase
    r = blank_result(ok);
    if (s >= 0 && ok) begin
      r.slot = SLOT_W'(s);
      r.result_clip = sl_clip[s];
    end
    pending_results.push_back(r);
  endfunction

  // First frame of a defined clip that was never loaded, -1 if all are
  function automatic int missing_frame(int c);
    for (int f = 0; f < clip_len[c]; f++)
      if (!fr_loaded[fidx(c, f)]) return f;
    return -1;
  endfunction

  function automatic int pick_clip();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 15);
  endfunction

  // Random request, mostly well formed; clips only play once fully loaded
  function automatic in_item_t random_request();
    in_item_t it;
    int r, c, m;
    it = IN_W'({$urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    c = pick_clip();
    it.clip_id = CLIP_W'(c);
    if (r < 10) begin
      it.req_type = REQ_DEFINE;
      it.mode = 3'(($urandom_range(0, 9) < 9) ? $urandom_range(0, 4) : $urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       it.frame_count = '0;
        1:       it.frame_count = FCNT_W'(MAX_FRAMES);
        2:       it.frame_count = FCNT_W'($urandom_range(17, 31));
        default: it.frame_count = FCNT_W'($urandom_range(1, 6));
      endcase
    end else if (r < 30 || (r < 45 && clip_ok[c] && missing_frame(c) >= 0)) begin
      it.req_type = REQ_LOAD;
      m = clip_ok[c] ? missing_frame(c) : -1;
      if (m >= 0 && $urandom_range(0, 9) < 8) it.frame_index = FRAME_W'(m);
      it.time_value = TIME_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 30) : $urandom);
    end else if (r < 45) begin
      it.req_type = REQ_PLAY;
    end else if (r < 55) begin
      it.req_type = 4'($urandom_range(REQ_STOP, REQ_RESUME));
    end else if (r < 72) begin
      it.req_type = REQ_TICK;
      it.time_value = TIME_W'(($urandom_range(0, 19) == 0) ? $urandom
                                                            : $urandom_range(0, 40));
    end else if (r < 82) begin
      it.req_type = REQ_RENDER;
    end else if (r < 92) begin
      it.req_type = REQ_QUERY;
    end else if (r < 94) begin
      it.req_type = REQ_STOP_ALL;
    end else if (r < 97) begin
      it.req_type = REQ_UNLOAD;
    end else begin
      it.req_type = 4'($urandom_range(11, 15));
    end
    return it;
  endfunction

  function automatic in_item_t req(logic [3:0] kind, int c, int md, int fc, int fi,
                                   int tv, int spr, int px, int py, int pr);
    in_item_t it;
    it.req_type = kind;
    it.clip_id = CLIP_W'(c);
    it.mode = 3'(md);
    it.frame_count = FCNT_W'(fc);
    it.frame_index = FRAME_W'(fi);
    it.time_value = TIME_W'(tv);
    it.sprite_frame = SPR_W'(spr);
    it.pos_x = POS_W'(px);
    it.pos_y = POS_W'(py);
    it.priority_req = PRIO_W'(pr);
    return it;
  endfunction

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    stim_row_t row;
    row.it = it;
    row.typed = typed;
    row.want = want;
    directed.push_back(row);
  endtask

  // Request side: offers one transaction, returns once it is accepted
  task automatic send_request(in_item_t it, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.req_type     <= it.req_type;
    in_if.clip_id      <= it.clip_id;
    in_if.mode         <= it.mode;
    in_if.frame_count  <= it.frame_count;
    in_if.frame_index  <= it.frame_index;
    in_if.time_value   <= it.time_value;
    in_if.sprite_frame <= it.sprite_frame;
    in_if.pos_x        <= it.pos_x;
    in_if.pos_y        <= it.pos_y;
    in_if.priority_req <= it.priority_req;
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    predict_request(it);
  endtask

  function automatic int draw_gap(int n);
    return (((n / 50) % 3) == 1) ? 0 : $urandom_range(0, 11);
  endfunction

  // Stimulus and end of run
  initial begin
    int n;
    in_if.valid <= 1'b0;
    {in_if.req_type, in_if.clip_id, in_if.mode, in_if.frame_count, in_if.frame_index,
     in_if.time_value, in_if.sprite_frame, in_if.pos_x, in_if.pos_y,
     in_if.priority_req} <= '0;
    for (int i = 0; i < NUM_CLIPS; i++) begin
      clip_ok[i] = 1'b0;
      clip_md[i] = '0;
      clip_len[i] = '0;
    end
    for (int i = 0; i < FDEPTH; i++) begin
      {fr_dur[i], fr_spr[i], fr_dx[i], fr_dy[i]} = '0;
      fr_loaded[i] = 1'b0;
    end
    for (int i = 0; i < NUM_INST; i++) begin
      {sl_act[i], sl_clip[i], sl_st[i], sl_frame[i], sl_timer[i]} = '0;
      {sl_back[i], sl_loops[i], sl_prio[i]} = '0;
    end
    rng = LFSR_SEED;

    // Directed table
    add_row(req(REQ_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            '{anim_state: ANIM_NOT_FOUND, last: 1'b1, default: '0});
    add_row(req(REQ_RENDER, 0, 0, 0, 0, 0, 0, 100, -100, 0));
    add_row(req(REQ_DEFINE, 0, MODE_LOOP, 2, 0, 0, 0, 0, 0, 0), 1'b1, blank_result(1'b1));
    add_row(req(REQ_DEFINE, 1, MODE_LOOP, 17, 0, 0, 0, 0, 0, 0), 1'b1, blank_result(1'b0));
    add_row(req(REQ_DEFINE, 1, 5, 3, 0, 0, 0, 0, 0, 0), 1'b1, blank_result(1'b0));
    add_row(req(REQ_DEFINE, 1, MODE_PINGPONG, 1, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_DEFINE, 2, MODE_RANDOM, 3, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_DEFINE, 4, MODE_HOLD, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_LOAD, 0, 0, 0, 0, 16'hFFFF, 255, 32767, -32768, 0));
    add_row(req(REQ_LOAD, 0, 0, 0, 1, 1, 0, -32768, 32767, 0));
    add_row(req(REQ_LOAD, 0, 0, 0, 2, 5, 7, 1, 1, 0), 1'b1, blank_result(1'b0));
    add_row(req(REQ_LOAD, 1, 0, 0, 0, 0, 9, -1, -1, 0));
    for (int f = 0; f < 3; f++) add_row(req(REQ_LOAD, 2, 0, 0, f, 2, 20 + f, f, -f, 0));
    add_row(req(REQ_PLAY, 0, 0, 0, 0, 0, 0, 0, 0, 255));
    add_row(req(REQ_PLAY, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_PLAY, 2, 0, 0, 0, 0, 0, 0, 0, 128));
    add_row(req(REQ_PLAY, 4, 0, 0, 0, 0, 0, 0, 0, 3));
    add_row(req(REQ_PLAY, 15, 0, 0, 0, 0, 0, 0, 0, 3), 1'b1, blank_result(1'b0));
    add_row(req(REQ_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
    add_row(req(REQ_RENDER, 0, 0, 0, 0, 0, 0, 32767, -32768, 0));
    add_row(req(REQ_PAUSE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_RESUME, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_QUERY, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(REQ_UNLOAD, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(req(4'd12, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, blank_result(1'b0));
    add_row(req(REQ_STOP_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, blank_result(1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n = 0;
    foreach (directed[k]) begin
      send_request(directed[k].it, draw_gap(n++));
      if (directed[k].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(directed[k].want);
      end
    end
    for (int k = 0; k < RAND_ITEMS; k++) send_request(random_request(), draw_gap(n++));
    in_if.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int taken;
    int w;
    taken = 0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      w = (((taken / 64) % 3) == 2) ? 0 : $urandom_range(0, 11);
      if (taken == 120) w = LONG_HOLD;
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      taken++;
    end
  end

  // Result check and watchdog
  always @(posedge clk) begin
    out_item_t want;
    bit bad;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          want = pending_results.pop_front();
          bad = out_if.req_ok !== want.req_ok || out_if.slot !== want.slot
             || out_if.result_clip !== want.result_clip
             || out_if.draw_valid !== want.draw_valid
             || out_if.draw_sprite !== want.draw_sprite
             || out_if.draw_x !== want.draw_x || out_if.draw_y !== want.draw_y
             || out_if.anim_state !== want.anim_state
             || out_if.current_frame !== want.current_frame
             || out_if.loop_count !== want.loop_count || out_if.last !== want.last;
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch at %0t:", $realtime);
              $display("  expected ok=%0d slot=%0d clip=%0d dv=%0d spr=%0d x=%0d y=%0d",
                       want.req_ok, want.slot, want.result_clip, want.draw_valid,
                       want.draw_sprite, want.draw_x, want.draw_y);
              $display("  expected st=%0d fr=%0d lp=%0d last=%0d",
                       want.anim_state, want.current_frame, want.loop_count, want.last);
              $display("  got ok=%0d slot=%0d clip=%0d dv=%0d spr=%0d x=%0d y=%0d",
                       out_if.req_ok, out_if.slot, out_if.result_clip, out_if.draw_valid,
                       out_if.draw_sprite, out_if.draw_x, out_if.draw_y);
              $display("  got st=%0d fr=%0d lp=%0d last=%0d",
                       out_if.anim_state, out_if.current_frame, out_if.loop_count,
                       out_if.last);
            end
          end
        end
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
